FILE: rtl/ycck_pkg.sv
// ----------------------------------------------------------------------------
// ycck_pkg
// shared types and constants for the 4:2:2 color key replace block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ycck_pkg;

    localparam int DEF_COEF_FRAC_BITS = 10;
    localparam int NUM_LANES          = 2;
    localparam int LANE_DEPTH         = 4;
    localparam int PIX_W              = 8;
    localparam int WORD_W             = 16;
    localparam int REG_IDX_W          = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RED_LOWER   = 3'd0,
        REG_RED_UPPER   = 3'd1,
        REG_GREEN_LOWER = 3'd2,
        REG_GREEN_UPPER = 3'd3,
        REG_BLUE_LOWER  = 3'd4,
        REG_FILL_RED    = 3'd5,
        REG_FILL_GREEN  = 3'd6,
        REG_FILL_BLUE   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_lower;
        logic [PIX_W-1:0] red_upper;
        logic [PIX_W-1:0] green_lower;
        logic [PIX_W-1:0] green_upper;
        logic [PIX_W-1:0] blue_lower;
        logic [PIX_W-1:0] fill_red;
        logic [PIX_W-1:0] fill_green;
        logic [PIX_W-1:0] fill_blue;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
        logic             hit;
    } lane_res_t;

endpackage

`default_nettype wire

FILE: rtl/ycck_lane.sv
// ----------------------------------------------------------------------------
// ycck_lane
// one pixel: ycbcr to rgb, key window test and fill, rgb back to ycbcr
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ycck_lane
    import ycck_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire cfg_t             cfg,
    input  wire logic [PIX_W-1:0] luma_in,
    input  wire logic [PIX_W-1:0] cb_in,
    input  wire logic [PIX_W-1:0] cr_in,
    output lane_res_t             res
);

    localparam int ACC_W = COEF_FRAC_BITS + 12;

    localparam logic signed [ACC_W-1:0] K_Y   = ACC_W'((1164 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_RV  = ACC_W'((1596 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_GV  = ACC_W'((813 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_GU  = ACC_W'((391 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_BU  = ACC_W'((2018 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_YR  = ACC_W'((257 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_YG  = ACC_W'((504 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_YB  = ACC_W'((98 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_BR  = ACC_W'((148 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_BG  = ACC_W'((291 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_439 = ACC_W'((439 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_RG  = ACC_W'((368 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] K_RB  = ACC_W'((71 << COEF_FRAC_BITS) / 1000);
    localparam logic signed [ACC_W-1:0] OFS_16  = ACC_W'(16 << COEF_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] OFS_128 = ACC_W'(128 << COEF_FRAC_BITS);

    function automatic logic [PIX_W-1:0] sat8(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0] sh;
        sh = ACC_W'(acc >>> COEF_FRAC_BITS);
        if (acc < 0) begin
            return '0;
        end else if (sh > ACC_W'(255)) begin
            return 8'hff;
        end else begin
            return sh[PIX_W-1:0];
        end
    endfunction

    // stage 1: forward products
    logic signed [8:0]       yy, uu, vv;
    logic signed [ACC_W-1:0] e_y, e_u, e_v;
    logic signed [ACC_W-1:0] p_y_reg, p_rv_reg, p_gv_reg, p_gu_reg, p_bu_reg;

    // stage 2: rgb
    logic [PIX_W-1:0] r_reg, g_reg, b_reg;

    // stage 3: keyed rgb
    logic [PIX_W-1:0] kr_reg, kg_reg, kb_reg;
    logic             hit_next, hit3_reg;

    // stage 4: backward products
    logic signed [ACC_W-1:0] e_r, e_g, e_b;
    logic signed [ACC_W-1:0] q_yr_reg, q_yg_reg, q_yb_reg;
    logic signed [ACC_W-1:0] q_br_reg, q_bg_reg, q_bb_reg;
    logic signed [ACC_W-1:0] q_rr_reg, q_rg_reg, q_rb_reg;
    logic                    hit4_reg;

    always_comb begin
        yy  = $signed({1'b0, luma_in}) - 9'sd16;
        uu  = $signed({1'b0, cb_in}) - 9'sd128;
        vv  = $signed({1'b0, cr_in}) - 9'sd128;
        e_y = ACC_W'(yy);
        e_u = ACC_W'(uu);
        e_v = ACC_W'(vv);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_y_reg  <= K_Y * e_y;
            p_rv_reg <= K_RV * e_v;
            p_gv_reg <= K_GV * e_v;
            p_gu_reg <= K_GU * e_u;
            p_bu_reg <= K_BU * e_u;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= sat8(p_y_reg + p_rv_reg);
            g_reg <= sat8(p_y_reg - p_gv_reg - p_gu_reg);
            b_reg <= sat8(p_y_reg + p_bu_reg);
        end
    end

    assign hit_next = (r_reg > cfg.red_lower) && (r_reg < cfg.red_upper) &&
                      (g_reg > cfg.green_lower) && (g_reg < cfg.green_upper) &&
                      (b_reg > cfg.blue_lower);

    always_ff @(posedge aclk) begin
        if (en) begin
            hit3_reg <= hit_next;
            kr_reg   <= hit_next ? cfg.fill_red   : r_reg;
            kg_reg   <= hit_next ? cfg.fill_green : g_reg;
            kb_reg   <= hit_next ? cfg.fill_blue  : b_reg;
        end
    end

    always_comb begin
        e_r = $signed(ACC_W'(kr_reg));
        e_g = $signed(ACC_W'(kg_reg));
        e_b = $signed(ACC_W'(kb_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit4_reg <= hit3_reg;
            q_yr_reg <= K_YR * e_r;
            q_yg_reg <= K_YG * e_g;
            q_yb_reg <= K_YB * e_b;
            q_br_reg <= K_BR * e_r;
            q_bg_reg <= K_BG * e_g;
            q_bb_reg <= K_439 * e_b;
            q_rr_reg <= K_439 * e_r;
            q_rg_reg <= K_RG * e_g;
            q_rb_reg <= K_RB * e_b;
        end
    end

    always_comb begin
        res.luma = sat8(OFS_16 + q_yr_reg + q_yg_reg + q_yb_reg);
        res.cb   = sat8(OFS_128 - q_br_reg - q_bg_reg + q_bb_reg);
        res.cr   = sat8(OFS_128 + q_rr_reg - q_rg_reg - q_rb_reg);
        res.hit  = hit4_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/ycck_merge.sv
// ----------------------------------------------------------------------------
// ycck_merge
// combines the two lanes into the output pair and holds it until taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ycck_merge
    import ycck_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire lane_res_t         lane0,
    input  wire lane_res_t         lane1,
    output logic                   advance,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [2*WORD_W-1:0]    m_tdata,
    output logic [NUM_LANES-1:0]   m_tuser
);

    logic                 valid_reg;
    logic [2*WORD_W-1:0]  data_reg, data_next;
    logic [NUM_LANES-1:0] user_reg, user_next;

    assign advance = !valid_reg || m_tready;

    // cb from the first pixel, cr from the second
    assign data_next = {lane1.cr, lane1.luma, lane0.cb, lane0.luma};
    assign user_next = {lane1.hit, lane0.hit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

`default_nettype wire

FILE: rtl/ycbcr422_color_key_replace.sv
// ----------------------------------------------------------------------------
// ycbcr422_color_key_replace
// bt.601 color key replacement on a 4:2:2 pixel pair, one lane per pixel
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tdata[15:0] first_word, tdata[31:16] second_word
//  m_*       out        tdata[15:0] first_word_out, tdata[31:16] second_word_out,
//                       tuser[0] first_replaced, tuser[1] second_replaced
//  cfg_*     in         write of key window and fill color, index 0..7
//
//  one item per cycle while the output is not stalled, through four lane stages and
//  the output register
//  the whole pipeline moves together, so an output stall holds every stage and
//  drops s_tready in the same cycle
//  synchronous active-low reset clears item valids and loads register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ycbcr422_color_key_replace
    import ycck_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [2*WORD_W-1:0]  s_tdata,      // first_word, second_word
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [2*WORD_W-1:0]       m_tdata,      // first_word_out, second_word_out
    output logic [NUM_LANES-1:0]      m_tuser,      // first_replaced, second_replaced
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_addr,
    input  wire logic [PIX_W-1:0]     cfg_wr_data
);

    cfg_t                  cfg_reg;
    logic                  advance;
    logic [LANE_DEPTH-1:0] vld_reg;
    logic [PIX_W-1:0]      luma_in [NUM_LANES];
    logic [PIX_W-1:0]      cb_in, cr_in;
    lane_res_t             lane_res [NUM_LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red_lower   <= 8'd60;
            cfg_reg.red_upper   <= 8'd80;
            cfg_reg.green_lower <= 8'd160;
            cfg_reg.green_upper <= 8'd180;
            cfg_reg.blue_lower  <= 8'd240;
            cfg_reg.fill_red    <= 8'd255;
            cfg_reg.fill_green  <= 8'd255;
            cfg_reg.fill_blue   <= 8'd0;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_RED_LOWER:   cfg_reg.red_lower   <= cfg_wr_data;
                REG_RED_UPPER:   cfg_reg.red_upper   <= cfg_wr_data;
                REG_GREEN_LOWER: cfg_reg.green_lower <= cfg_wr_data;
                REG_GREEN_UPPER: cfg_reg.green_upper <= cfg_wr_data;
                REG_BLUE_LOWER:  cfg_reg.blue_lower  <= cfg_wr_data;
                REG_FILL_RED:    cfg_reg.fill_red    <= cfg_wr_data;
                REG_FILL_GREEN:  cfg_reg.fill_green  <= cfg_wr_data;
                REG_FILL_BLUE:   cfg_reg.fill_blue   <= cfg_wr_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[LANE_DEPTH-2:0], s_tvalid};
        end
    end

    assign luma_in[0] = s_tdata[PIX_W-1:0];
    assign cb_in      = s_tdata[WORD_W-1:PIX_W];
    assign luma_in[1] = s_tdata[WORD_W+PIX_W-1:WORD_W];
    assign cr_in      = s_tdata[2*WORD_W-1:WORD_W+PIX_W];

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        ycck_lane #(
            .COEF_FRAC_BITS(COEF_FRAC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .en      (advance),
            .cfg     (cfg_reg),
            .luma_in (luma_in[i]),
            .cb_in   (cb_in),
            .cr_in   (cr_in),
            .res     (lane_res[i])
        );
    end

    ycck_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (vld_reg[LANE_DEPTH-1]),
        .lane0    (lane_res[0]),
        .lane1    (lane_res[1]),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: rtl/ycck_checker.sv
// ----------------------------------------------------------------------------
// ycck_checker
// port-level checks on the color key replace block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ycck_checker
    import ycck_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [2*WORD_W-1:0]  m_tdata,
    input wire logic [NUM_LANES-1:0] m_tuser
);

    // a held item keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // input is taken exactly when the output can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

endmodule

bind ycbcr422_color_key_replace ycck_checker u_ycck_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/sv/ycbcr422_color_key_replace_checker.sv
// ----------------------------------------------------------------------------
// ycbcr422_color_key_replace_checker
// watches both streams and the register port, predicts every recoded pixel
// pair with its own bt.601 fixed point model and compares it with the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ycbcr422_color_key_replace_checker
    import ycck_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [2*WORD_W-1:0]  s_tdata,      // first_word, second_word
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [2*WORD_W-1:0]  m_tdata,      // first_word_out, second_word_out
    input  wire logic [NUM_LANES-1:0] m_tuser,      // first_replaced, second_replaced
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_addr,
    input  wire logic [PIX_W-1:0]     cfg_wr_data,
    output int                        error_count,
    output int                        awaiting,
    output int                        result_count,
    output int                        replaced_count
);

    localparam int FRAC = DEF_COEF_FRAC_BITS;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        logic [WORD_W-1:0] first_word_out;
        logic [WORD_W-1:0] second_word_out;
        logic              first_replaced;
        logic              second_replaced;
    } recoded_pair_t;

    cfg_t          key_cfg;
    recoded_pair_t recoded_queue[$];

    function automatic longint coef(int milli);
        return (longint'(milli) <<< FRAC) / 1000;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_scaled(longint acc);
        longint v;
        if (acc < 0) return 8'd0;
        v = acc >>> FRAC;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic rgb_t ycbcr_to_rgb(int y, int cb, int cr);
        longint yy;
        longint u;
        longint v;
        longint base;
        rgb_t   p;
        yy   = y - 16;
        u    = cb - 128;
        v    = cr - 128;
        base = coef(1164) * yy;
        p.r  = clamp_scaled(base + coef(1596) * v);
        p.g  = clamp_scaled(base - coef(813) * v - coef(391) * u);
        p.b  = clamp_scaled(base + coef(2018) * u);
        return p;
    endfunction

    function automatic logic in_key_window(rgb_t p, cfg_t c);
        return p.r > c.red_lower && p.r < c.red_upper &&
               p.g > c.green_lower && p.g < c.green_upper &&
               p.b > c.blue_lower;
    endfunction

    function automatic rgb_t fill_color(cfg_t c);
        rgb_t p;
        p.r = c.fill_red;
        p.g = c.fill_green;
        p.b = c.fill_blue;
        return p;
    endfunction

    function automatic logic [PIX_W-1:0] luma_of(rgb_t p);
        int r;
        int g;
        int b;
        r = p.r;
        g = p.g;
        b = p.b;
        return clamp_scaled((longint'(16) <<< FRAC) + coef(257) * r + coef(504) * g +
                            coef(98) * b);
    endfunction

    function automatic logic [PIX_W-1:0] blue_diff_of(rgb_t p);
        int r;
        int g;
        int b;
        r = p.r;
        g = p.g;
        b = p.b;
        return clamp_scaled((longint'(128) <<< FRAC) - coef(148) * r - coef(291) * g +
                            coef(439) * b);
    endfunction

    function automatic logic [PIX_W-1:0] red_diff_of(rgb_t p);
        int r;
        int g;
        int b;
        r = p.r;
        g = p.g;
        b = p.b;
        return clamp_scaled((longint'(128) <<< FRAC) + coef(439) * r - coef(368) * g -
                            coef(71) * b);
    endfunction

    function automatic recoded_pair_t recode_pair(logic [2*WORD_W-1:0] din, cfg_t c);
        rgb_t          p1;
        rgb_t          p2;
        recoded_pair_t o;
        int            y1;
        int            cb;
        int            y2;
        int            cr;
        y1 = din[7:0];
        cb = din[15:8];
        y2 = din[23:16];
        cr = din[31:24];
        p1 = ycbcr_to_rgb(y1, cb, cr);
        p2 = ycbcr_to_rgb(y2, cb, cr);
        o.first_replaced  = in_key_window(p1, c);
        o.second_replaced = in_key_window(p2, c);
        if (o.first_replaced) p1 = fill_color(c);
        if (o.second_replaced) p2 = fill_color(c);
        o.first_word_out  = {blue_diff_of(p1), luma_of(p1)};
        o.second_word_out = {red_diff_of(p2), luma_of(p2)};
        return o;
    endfunction

    task automatic report_field(string label, int want, int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        recoded_pair_t want;
        recoded_pair_t got;
        if (!aresetn) begin
            key_cfg = '{red_lower: 8'd60, red_upper: 8'd80, green_lower: 8'd160,
                        green_upper: 8'd180, blue_lower: 8'd240, fill_red: 8'd255,
                        fill_green: 8'd255, fill_blue: 8'd0};
            recoded_queue.delete();
        end else begin
            if (s_tvalid && s_tready) recoded_queue.push_back(recode_pair(s_tdata, key_cfg));
            if (m_tvalid && m_tready) begin
                got.first_word_out  = m_tdata[15:0];
                got.second_word_out = m_tdata[31:16];
                got.first_replaced  = m_tuser[0];
                got.second_replaced = m_tuser[1];
                result_count++;
                replaced_count += got.first_replaced + got.second_replaced;
                if (recoded_queue.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected output item, actual %h %h", $time, m_tdata,
                             m_tuser);
                end else begin
                    want = recoded_queue.pop_front();
                    report_field("first_word_out", want.first_word_out, got.first_word_out);
                    report_field("second_word_out", want.second_word_out,
                                 got.second_word_out);
                    report_field("first_replaced", want.first_replaced, got.first_replaced);
                    report_field("second_replaced", want.second_replaced,
                                 got.second_replaced);
                end
            end
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_addr))
                    REG_RED_LOWER:   key_cfg.red_lower   = cfg_wr_data;
                    REG_RED_UPPER:   key_cfg.red_upper   = cfg_wr_data;
                    REG_GREEN_LOWER: key_cfg.green_lower = cfg_wr_data;
                    REG_GREEN_UPPER: key_cfg.green_upper = cfg_wr_data;
                    REG_BLUE_LOWER:  key_cfg.blue_lower  = cfg_wr_data;
                    REG_FILL_RED:    key_cfg.fill_red    = cfg_wr_data;
                    REG_FILL_GREEN:  key_cfg.fill_green  = cfg_wr_data;
                    REG_FILL_BLUE:   key_cfg.fill_blue   = cfg_wr_data;
                    default: ;
                endcase
            end
        end
        awaiting = recoded_queue.size();
    end

endmodule

FILE: tb/sv/ycbcr422_color_key_replace_test.sv
// ----------------------------------------------------------------------------
// ycbcr422_color_key_replace_test
// drives pixel pairs and key window settings into the color key replace block
// with random gaps and output stalls; the checker beside the block predicts
// and compares every output item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ycbcr422_color_key_replace_test;
    import ycck_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_ITEMS = 850;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [2*WORD_W-1:0]  s_tdata     = '0;   // first_word, second_word
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [2*WORD_W-1:0]  m_tdata;            // first_word_out, second_word_out
    logic [NUM_LANES-1:0] m_tuser;            // first_replaced, second_replaced
    logic                 cfg_wr_en   = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr    = REG_RED_LOWER;
    logic [PIX_W-1:0]     cfg_wr_data = '0;

    int check_errors;
    int pending_results;
    int results_seen;
    int pixels_replaced;
    int cycle_count    = 0;
    int items_sent     = 0;
    int settings_count = 0;
    bit burst_mode     = 1'b0;

    ycbcr422_color_key_replace dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    ycbcr422_color_key_replace_checker recode_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .error_count    (check_errors),
        .awaiting       (pending_results),
        .result_count   (results_seen),
        .replaced_count (pixels_replaced)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results);
            $display("ycbcr422_color_key_replace_test: FAIL");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] clip8(int v);
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [2*WORD_W-1:0] pack(int cb, int y1, int cr, int y2);
        return {cr[7:0], y2[7:0], cb[7:0], y1[7:0]};
    endfunction

    function automatic logic [PIX_W-1:0] near(int c, int j);
        return clip8(c + int'($urandom_range(0, 2 * j)) - j);
    endfunction

    // pair scattered around a chosen pixel so that hits near the window are common
    function automatic logic [2*WORD_W-1:0] aimed_pair(int cy, int ccb, int ccr);
        int j;
        j = $urandom_range(0, 4);
        return pack(near(ccb, j), near(cy, j), near(ccr, j), near(cy, j));
    endfunction

    // rough rgb of a pixel, only used to place key windows
    function automatic void approx_rgb(input int y, input int cb, input int cr,
                                       output int r, output int g, output int b);
        real yy;
        yy = 1.164 * (y - 16);
        r  = $rtoi(yy + 1.596 * (cr - 128));
        g  = $rtoi(yy - 0.813 * (cr - 128) - 0.391 * (cb - 128));
        b  = $rtoi(yy + 2.018 * (cb - 128));
    endfunction

    function automatic logic [PIX_W-1:0] pick_fill();
        int k;
        k = $urandom_range(0, 3);
        if (k == 0) return 8'd0;
        if (k == 1) return 8'd255;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic send_pair(input logic [2*WORD_W-1:0] pair);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = pair;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PIX_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = value;
    endtask

    task automatic write_window(input cfg_t w);
        write_reg(REG_RED_LOWER, w.red_lower);
        write_reg(REG_RED_UPPER, w.red_upper);
        write_reg(REG_GREEN_LOWER, w.green_lower);
        write_reg(REG_GREEN_UPPER, w.green_upper);
        write_reg(REG_BLUE_LOWER, w.blue_lower);
        write_reg(REG_FILL_RED, w.fill_red);
        write_reg(REG_FILL_GREEN, w.fill_green);
        write_reg(REG_FILL_BLUE, w.fill_blue);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        settings_count++;
    endtask

    task automatic run_phase(input cfg_t w, input int cy, input int ccb, input int ccr,
                             input int count, input int aim_pct, input bit burst);
        write_window(w);
        burst_mode = burst;
        repeat (count) begin
            if ($urandom_range(0, 99) < aim_pct) send_pair(aimed_pair(cy, ccb, ccr));
            else send_pair($urandom());
        end
        drain();
        burst_mode = 1'b0;
    endtask

    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            int stall;
            stall = burst_mode ? 0 : $urandom_range(0, 15);
            repeat (stall) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        cfg_t w;
        int   cy;
        int   ccb;
        int   ccr;
        int   r;
        int   g;
        int   b;

        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        settings_count = 1;

        // reset window: field extremes, saturation, and pairs on the key
        send_pair(pack(0, 0, 0, 0));
        send_pair(pack(255, 255, 255, 255));
        send_pair(pack(0, 255, 255, 0));
        send_pair(pack(255, 0, 0, 255));
        send_pair(pack(128, 16, 128, 235));
        send_pair(pack(128, 235, 128, 16));
        send_pair(pack(128, 128, 128, 128));
        send_pair(pack(255, 255, 0, 0));
        send_pair(pack(128, 0, 128, 255));
        send_pair(pack(178, 144, 78, 144));
        send_pair(pack(178, 144, 78, 200));
        send_pair(pack(178, 200, 78, 144));
        send_pair(pack(178, 143, 78, 145));
        send_pair(pack(179, 144, 77, 144));
        send_pair(pack(240, 180, 16, 40));
        send_pair(pack(16, 40, 240, 180));
        drain();

        // widest window, black fill
        w = '{red_lower: 8'd0, red_upper: 8'd255, green_lower: 8'd0, green_upper: 8'd255,
              blue_lower: 8'd0, fill_red: 8'd0, fill_green: 8'd0, fill_blue: 8'd0};
        run_phase(w, 128, 128, 128, 80, 50, 1'b0);

        // red range closed by one step, aimed right at it
        w = '{red_lower: 8'd68, red_upper: 8'd69, green_lower: 8'd160, green_upper: 8'd180,
              blue_lower: 8'd240, fill_red: 8'd255, fill_green: 8'd0, fill_blue: 8'd255};
        run_phase(w, 144, 178, 78, 40, 100, 1'b1);

        // inverted bounds at the register extremes
        w = '{red_lower: 8'd255, red_upper: 8'd0, green_lower: 8'd255, green_upper: 8'd0,
              blue_lower: 8'd255, fill_red: 8'd255, fill_green: 8'd255, fill_blue: 8'd255};
        run_phase(w, 128, 128, 128, 30, 0, 1'b0);

        while (items_sent < TARGET_ITEMS) begin
            cy  = $urandom_range(16, 235);
            ccb = $urandom_range(16, 240);
            ccr = $urandom_range(16, 240);
            approx_rgb(cy, ccb, ccr, r, g, b);
            w.red_lower   = clip8(r - int'($urandom_range(1, 40)));
            w.red_upper   = clip8(r + int'($urandom_range(1, 40)));
            w.green_lower = clip8(g - int'($urandom_range(1, 40)));
            w.green_upper = clip8(g + int'($urandom_range(1, 40)));
            w.blue_lower  = clip8(b - int'($urandom_range(1, 40)));
            if ($urandom_range(0, 5) == 0 && w.green_lower < 8'd255)
                w.green_upper = w.green_lower + 8'd1;
            w.fill_red   = pick_fill();
            w.fill_green = pick_fill();
            w.fill_blue  = pick_fill();
            run_phase(w, cy, ccb, ccr, $urandom_range(50, 100), 75, settings_count % 3 == 0);
        end

        drain();
        $display("run covered %0d pixel pairs under %0d key window settings",
                 items_sent, settings_count);
        $display("%0d output items checked, %0d pixels replaced by the fill color",
                 results_seen, pixels_replaced);
        if (check_errors == 0 && pending_results == 0) begin
            $display("ycbcr422_color_key_replace_test: PASS");
        end else begin
            $display("ycbcr422_color_key_replace_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ycck_pkg.sv
rtl/ycck_lane.sv
rtl/ycck_merge.sv
rtl/ycbcr422_color_key_replace.sv
rtl/ycck_checker.sv
tb/sv/ycbcr422_color_key_replace_checker.sv
tb/sv/ycbcr422_color_key_replace_test.sv
